/* rtl/core/single_wire_start_and_byte_read_defines.svh */
// Assertion macros for the single-wire start and byte read block.
// Used by the port checker; expects aclk and aresetn in scope.
`ifndef SINGLE_WIRE_START_AND_BYTE_READ_DEFINES_SVH
`define SINGLE_WIRE_START_AND_BYTE_READ_DEFINES_SVH

// same-cycle implication
`define SWSBR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWSBR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/swsbr_pkg.sv */
// Shared types and constants for the single-wire start and byte read block.
// No dependencies.
`default_nettype none

package swsbr_pkg;

    localparam int TIMER_W = 18;

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_START_OK = 2'd1;
    localparam logic [1:0] ST_START_ERR = 2'd2;
    localparam logic [1:0] ST_BYTE    = 2'd3;

    localparam logic [7:0]         LOW_MS_RESET = 8'd18;
    localparam logic [TIMER_W-1:0] TICKS_PER_MS = 18'd1000;

    typedef struct packed {
        logic       drive_enable;
        logic       drive_value;
        logic       busy_res;
        logic [1:0] status;
        logic [7:0] data_byte;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/single_wire_start_and_byte_read.sv */
// Top level of the single-wire start handshake and byte read master.
// Instantiates swsbr_core and swsbr_outreg; uses swsbr_pkg.
// One item is one 1 us tick and yields exactly one result item. An item is
// taken every cycle as long as the result register is empty or being read, and
// its result appears on the m_ side the cycle after acceptance; the result
// register sets that step. A start holds the line low for start_low_ms*1000
// ticks (18 ms after reset), drives it high for 20 ticks, then checks the
// sensor response; a read gathers 8 bits MSB first. Waits on the line level
// have no timeout. Write start_low_ms only while no start or read is in
// progress.
`default_nettype none

module single_wire_start_and_byte_read (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_mode,
    input  wire logic       s_line_level,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_drive_enable,
    output logic            m_drive_value,
    output logic            m_busy_res,
    output logic [1:0]      m_status,
    output logic [7:0]      m_data_byte
);

    swsbr_pkg::result_t step_result;
    swsbr_pkg::result_t out_result;
    logic               accept;

    assign accept = s_valid && s_ready;

    swsbr_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .item_accept (accept),
        .mode        (s_mode),
        .line_level  (s_line_level),
        .result      (step_result)
    );

    swsbr_outreg u_outreg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_result  (step_result),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (out_result)
    );

    assign m_drive_enable = out_result.drive_enable;
    assign m_drive_value  = out_result.drive_value;
    assign m_busy_res     = out_result.busy_res;
    assign m_status       = out_result.status;
    assign m_data_byte    = out_result.data_byte;

endmodule

`default_nettype wire

/* rtl/core/swsbr_core.sv */
// Sequencer for the start handshake and byte read: phase, timer, bit count
// and shift register, advanced once per accepted item. Uses swsbr_pkg.
`default_nettype none

module swsbr_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_wdata,
    input  wire logic              item_accept,
    input  wire logic [1:0]        mode,
    input  wire logic              line_level,
    output swsbr_pkg::result_t     result
);

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_LOW       = 4'd1;
    localparam logic [3:0] PH_HIGH      = 4'd2;
    localparam logic [3:0] PH_CHECK     = 4'd3;
    localparam logic [3:0] PH_RESP_LOW  = 4'd4;
    localparam logic [3:0] PH_RESP_HIGH = 4'd5;
    localparam logic [3:0] PH_GAP       = 4'd6;
    localparam logic [3:0] PH_WAITHIGH  = 4'd7;
    localparam logic [3:0] PH_HOLD      = 4'd8;
    localparam logic [3:0] PH_SAMPLE    = 4'd9;
    localparam logic [3:0] PH_TAIL      = 4'd10;

    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam int TW = swsbr_pkg::TIMER_W;
    localparam logic [TW-1:0] TICKS_GAP  = TW'(20);
    localparam logic [TW-1:0] TICKS_HOLD = TW'(30);
    localparam logic [TW-1:0] TICKS_ONE  = TW'(1);
    localparam logic [3:0]    BITS_PER_BYTE = 4'd8;

    logic [TW-1:0] low_len_reg, low_len_next;
    logic [3:0]    phase_reg, phase_next;
    logic [TW-1:0] timer_reg, timer_next;
    logic [3:0]    bit_cnt_reg, bit_cnt_next;
    logic [7:0]    shift_reg, shift_next;

    logic          tm_done;
    logic [TW-1:0] tm_dec;
    logic          bit_done;

    // low length precomputed at write time; 255 ms fits in the timer
    assign low_len_next = TW'({{(TW-8){1'b0}}, cfg_wdata} * swsbr_pkg::TICKS_PER_MS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_len_reg <= TW'(swsbr_pkg::LOW_MS_RESET) * swsbr_pkg::TICKS_PER_MS;
        end else if (cfg_we) begin
            low_len_reg <= low_len_next;
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        result       = '0;
        bit_done     = 1'b0;

        if (phase_reg == PH_IDLE) begin
            if (mode == MODE_START) begin
                phase_next = PH_LOW;
                timer_next = low_len_reg;
            end else if (mode == MODE_READ) begin
                phase_next   = PH_GAP;
                timer_next   = TICKS_GAP;
                bit_cnt_next = 4'd0;
                shift_next   = 8'd0;
            end
        end

        tm_done = (timer_next <= TICKS_ONE);
        tm_dec  = timer_next - TICKS_ONE;

        case (phase_next)
            PH_IDLE: begin
            end
            PH_LOW: begin
                result.drive_enable = 1'b1;
                if (tm_done) begin
                    phase_next = PH_HIGH;
                    timer_next = TICKS_GAP;
                end else begin
                    timer_next = tm_dec;
                end
            end
            PH_HIGH: begin
                result.drive_enable = 1'b1;
                result.drive_value  = 1'b1;
                if (tm_done) begin
                    phase_next = PH_CHECK;
                end else begin
                    timer_next = tm_dec;
                end
            end
            PH_CHECK: begin
                if (!line_level) begin
                    phase_next = PH_RESP_LOW;
                end else begin
                    result.status = swsbr_pkg::ST_START_ERR;
                    phase_next    = PH_IDLE;
                end
            end
            PH_RESP_LOW: begin
                if (line_level) begin
                    phase_next = PH_RESP_HIGH;
                end
            end
            PH_RESP_HIGH: begin
                if (!line_level) begin
                    result.status = swsbr_pkg::ST_START_OK;
                    phase_next    = PH_IDLE;
                end
            end
            PH_GAP: begin
                if (tm_done) begin
                    phase_next = PH_WAITHIGH;
                end else begin
                    timer_next = tm_dec;
                end
            end
            PH_WAITHIGH: begin
                if (line_level) begin
                    phase_next = PH_HOLD;
                    timer_next = TICKS_HOLD;
                end
            end
            PH_HOLD: begin
                if (tm_done) begin
                    phase_next = PH_SAMPLE;
                end else begin
                    timer_next = tm_dec;
                end
            end
            PH_SAMPLE: begin
                shift_next = {shift_next[6:0], line_level};
                if (line_level) begin
                    phase_next = PH_TAIL;
                    timer_next = TICKS_HOLD;
                end else begin
                    bit_done = 1'b1;
                end
            end
            PH_TAIL: begin
                if (tm_done) begin
                    bit_done = 1'b1;
                end else begin
                    timer_next = tm_dec;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        if (bit_done) begin
            bit_cnt_next = bit_cnt_next + 4'd1;
            if (bit_cnt_next >= BITS_PER_BYTE) begin
                result.status    = swsbr_pkg::ST_BYTE;
                result.data_byte = shift_next;
                phase_next       = PH_IDLE;
            end else begin
                phase_next = PH_GAP;
                timer_next = TICKS_GAP;
            end
        end

        result.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            timer_reg   <= '0;
            bit_cnt_reg <= '0;
            shift_reg   <= '0;
        end else if (item_accept) begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/swsbr_outreg.sv */
// Result register for the single-wire block: holds one result item until taken.
// Uses swsbr_pkg.
`default_nettype none

module swsbr_outreg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire swsbr_pkg::result_t in_result,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output swsbr_pkg::result_t      out_result
);

    logic               valid_reg, valid_next;
    swsbr_pkg::result_t result_reg;
    logic               load;

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= in_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

/* rtl/core/swsbr_checker.sv */
// Port-level checks for single_wire_start_and_byte_read, bound to the top level.
// Uses swsbr_pkg and single_wire_start_and_byte_read_defines.svh.
`default_nettype none
`include "single_wire_start_and_byte_read_defines.svh"

module swsbr_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_drive_enable,
    input wire logic       m_drive_value,
    input wire logic       m_busy_res,
    input wire logic [1:0] m_status,
    input wire logic [7:0] m_data_byte
);

    `SWSBR_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "result item dropped while stalled")
    `SWSBR_ASSERT_NEXT(a_item_result, s_valid && s_ready, m_valid, "accepted item gave no result")
    `SWSBR_ASSERT_SAME(a_done_not_busy, m_valid && (m_status != swsbr_pkg::ST_NONE), !m_busy_res, "completion reported while busy")
    `SWSBR_ASSERT_SAME(a_data_only_byte, m_valid && (m_status != swsbr_pkg::ST_BYTE), m_data_byte == 8'd0, "data without byte status")
    `SWSBR_ASSERT_SAME(a_drive_high_en, m_valid && m_drive_value, m_drive_enable, "drive value without enable")

endmodule

bind single_wire_start_and_byte_read swsbr_checker u_checker (.*);

`default_nettype wire

/* verif/tb_single_wire_start_and_byte_read.sv */
// Testbench for single_wire_start_and_byte_read: drives 1 us ticks, predicts each
// result item with a cycle model of the bus sequencer and checks it field by field.
// Depends on swsbr_pkg and the RTL top level only.
module tb_single_wire_start_and_byte_read;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        MODE_TICK,
        MODE_START,
        MODE_READ,
        MODE_RSVD
    } mode_t;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_LOW,
        SEQ_HIGH,
        SEQ_CHECK,
        SEQ_RESP_LOW,
        SEQ_RESP_HIGH,
        SEQ_GAP,
        SEQ_WAIT_HIGH,
        SEQ_HOLD,
        SEQ_SAMPLE,
        SEQ_TAIL
    } seq_phase_t;

    typedef struct packed {
        seq_phase_t                    ph;
        logic [swsbr_pkg::TIMER_W-1:0] timer;
        logic [3:0]                    bits;
        logic [7:0]                    shreg;
    } bus_state_t;

    localparam logic [swsbr_pkg::TIMER_W-1:0] HIGH_TICKS = 18'd20;
    localparam logic [swsbr_pkg::TIMER_W-1:0] GAP_TICKS  = 18'd20;
    localparam logic [swsbr_pkg::TIMER_W-1:0] HOLD_TICKS = 18'd30;
    localparam logic [swsbr_pkg::TIMER_W-1:0] TAIL_TICKS = 18'd30;
    localparam logic [3:0]                    BYTE_BITS  = 4'd8;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_ITEMS   = 30;
    localparam int FINAL_ITEMS    = 20;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_mode = 2'd0;
    logic       s_line_level = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_drive_enable;
    logic       m_drive_value;
    logic       m_busy_res;
    logic [1:0] m_status;
    logic [7:0] m_data_byte;

    logic [2:0]         pending_ticks[$];
    swsbr_pkg::result_t predicted_results[$];
    swsbr_pkg::result_t tick_res;
    swsbr_pkg::result_t want;
    bus_state_t         model_st;
    bus_state_t         plan_st;
    logic [7:0]         model_low_ms;
    logic [7:0]         plan_low_ms;
    int                 errors;
    int                 items_queued;
    int                 idle_cycles;
    int                 src_gap;
    int                 snk_gap;
    bit                 src_idle_on;
    bit                 snk_idle_on;

    always #10 aclk = ~aclk;

    single_wire_start_and_byte_read dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_line_level   (s_line_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drive_enable (m_drive_enable),
        .m_drive_value  (m_drive_value),
        .m_busy_res     (m_busy_res),
        .m_status       (m_status),
        .m_data_byte    (m_data_byte)
    );

    // One tick of the bus sequencer: next state plus the result item of this tick.
    function automatic bus_state_t bus_tick(input bus_state_t cur, input logic [1:0] mode,
                                            input logic line, input logic [7:0] low_ms,
                                            output swsbr_pkg::result_t res);
        bus_state_t st;
        logic       expired;
        logic       bit_done;
        st = cur;
        res = '0;
        bit_done = 1'b0;
        if (st.ph == SEQ_IDLE) begin
            if (mode == MODE_START) begin
                st.ph = SEQ_LOW;
                st.timer = low_ms * swsbr_pkg::TICKS_PER_MS;
            end else if (mode == MODE_READ) begin
                st.ph = SEQ_GAP;
                st.timer = GAP_TICKS;
                st.bits = '0;
                st.shreg = '0;
            end
        end
        expired = (st.timer <= 18'd1);
        case (st.ph)
            SEQ_LOW: begin
                res.drive_enable = 1'b1;
                if (expired) begin
                    st.ph = SEQ_HIGH;
                    st.timer = HIGH_TICKS;
                end else begin
                    st.timer = st.timer - 18'd1;
                end
            end
            SEQ_HIGH: begin
                res.drive_enable = 1'b1;
                res.drive_value = 1'b1;
                if (expired) st.ph = SEQ_CHECK;
                else st.timer = st.timer - 18'd1;
            end
            SEQ_CHECK: begin
                if (!line) begin
                    st.ph = SEQ_RESP_LOW;
                end else begin
                    res.status = swsbr_pkg::ST_START_ERR;
                    st.ph = SEQ_IDLE;
                end
            end
            SEQ_RESP_LOW: begin
                if (line) st.ph = SEQ_RESP_HIGH;
            end
            SEQ_RESP_HIGH: begin
                if (!line) begin
                    res.status = swsbr_pkg::ST_START_OK;
                    st.ph = SEQ_IDLE;
                end
            end
            SEQ_GAP: begin
                if (expired) st.ph = SEQ_WAIT_HIGH;
                else st.timer = st.timer - 18'd1;
            end
            SEQ_WAIT_HIGH: begin
                if (line) begin
                    st.ph = SEQ_HOLD;
                    st.timer = HOLD_TICKS;
                end
            end
            SEQ_HOLD: begin
                if (expired) st.ph = SEQ_SAMPLE;
                else st.timer = st.timer - 18'd1;
            end
            SEQ_SAMPLE: begin
                st.shreg = {st.shreg[6:0], line};
                if (line) begin
                    st.ph = SEQ_TAIL;
                    st.timer = TAIL_TICKS;
                end else begin
                    bit_done = 1'b1;
                end
            end
            SEQ_TAIL: begin
                if (expired) bit_done = 1'b1;
                else st.timer = st.timer - 18'd1;
            end
            default: st.ph = SEQ_IDLE;
        endcase
        if (bit_done) begin
            st.bits = st.bits + 4'd1;
            if (st.bits >= BYTE_BITS) begin
                res.status = swsbr_pkg::ST_BYTE;
                res.data_byte = st.shreg;
                st.ph = SEQ_IDLE;
            end else begin
                st.ph = SEQ_GAP;
                st.timer = GAP_TICKS;
            end
        end
        res.busy_res = (st.ph != SEQ_IDLE);
        return st;
    endfunction

    function automatic void check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            errors++;
        end
    endfunction

    // Queue one tick and advance the planning copy of the sequencer.
    task automatic put(input logic [1:0] mode, input logic line);
        swsbr_pkg::result_t unused;
        items_queued++;
        plan_st = bus_tick(plan_st, mode, line, plan_low_ms, unused);
        pending_ticks.push_back({mode, line});
    endtask

    // Feed line levels that walk the running operation to its end.
    task automatic finish_op(input logic [7:0] byte_val, input logic no_answer, input bit stray);
        logic       line;
        logic [1:0] mode;
        while (plan_st.ph != SEQ_IDLE) begin
            case (plan_st.ph)
                SEQ_CHECK:                   line = no_answer;
                SEQ_SAMPLE:                  line = byte_val[7 - plan_st.bits];
                SEQ_WAIT_HIGH, SEQ_RESP_LOW: line = ($urandom_range(3) == 0);
                SEQ_RESP_HIGH:               line = ($urandom_range(3) != 0);
                default:                     line = 1'($urandom_range(1));
            endcase
            mode = MODE_TICK;
            if (stray && $urandom_range(39) == 0) mode = 2'($urandom_range(3, 1));
            put(mode, line);
        end
    endtask

    task automatic run_op(input mode_t cmd, input logic [7:0] byte_val, input logic no_answer,
                          input bit stray);
        put(cmd, 1'($urandom_range(1)));
        finish_op(byte_val, no_answer, stray);
    endtask

    // Short starts and plain or reserved ticks until the item goal is queued.
    task automatic random_ops(input int goal);
        int pick;
        items_queued = 0;
        while (items_queued < goal) begin
            pick = $urandom_range(19);
            if (pick < 8) begin
                run_op(MODE_START, 8'd0, $urandom_range(4) == 0, 1'b1);
            end else if (pick < 16) begin
                put(MODE_TICK, 1'($urandom_range(1)));
            end else begin
                put(MODE_RSVD, 1'($urandom_range(1)));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() != 0 || predicted_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_low_ms(input logic [7:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        model_low_ms = value;
        plan_low_ms = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Sender: accepted items go through the predictor, then the next one is offered.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
            model_st = '0;
        end else begin
            if (s_valid && s_ready) begin
                model_st = bus_tick(model_st, s_mode, s_line_level, model_low_ms, tick_res);
                predicted_results.push_back(tick_res);
                void'(pending_ticks.pop_front());
            end
            if (!s_valid || s_ready) begin
                if (src_gap == 0 && src_idle_on && $urandom_range(15) == 0)
                    src_gap = $urandom_range(12, 1);
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    s_valid <= 1'b1;
                    s_mode <= pending_ticks[0][2:1];
                    s_line_level <= pending_ticks[0][0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: compare each result item with the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t ns: result item arrived with none predicted", $time);
                    errors++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("drive_enable", want.drive_enable, m_drive_enable);
                    check_field("drive_value", want.drive_value, m_drive_value);
                    check_field("busy_res", want.busy_res, m_busy_res);
                    check_field("status", want.status, m_status);
                    check_field("data_byte", want.data_byte, m_data_byte);
                end
            end
            if (snk_gap == 0 && snk_idle_on && $urandom_range(15) == 0)
                snk_gap = $urandom_range(12, 1);
            if (snk_gap > 0) begin
                snk_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no handshake for %0d cycles", $time, idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        errors = 0;
        items_queued = 0;
        idle_cycles = 0;
        plan_st = '0;
        model_st = '0;
        plan_low_ms = swsbr_pkg::LOW_MS_RESET;
        model_low_ms = swsbr_pkg::LOW_MS_RESET;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // plain and reserved ticks
        put(MODE_TICK, 1'b0);
        put(MODE_RSVD, 1'b1);

        // zero low time: one driven-low tick
        set_low_ms(8'd0);
        run_op(MODE_START, 8'd0, 1'b1, 1'b0);
        run_op(MODE_START, 8'd0, 1'b0, 1'b1);

        // one byte, MSB first, commands while busy
        run_op(MODE_READ, 8'h83, 1'b0, 1'b1);

        random_ops(RANDOM_ITEMS);

        // no idling on either side
        wait_drained();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        random_ops(FINAL_ITEMS);

        wait_drained();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
